@@ hw/rtl/mrf_pkg.sv @@
// Shared types and constants for the modem response framer.
package mrf_pkg;

	localparam int MAX_LENGTH_DIGITS_DEF = 4;
	localparam int RESPONSE_DEPTH_DEF = 256;

	localparam int LEN_W = 14;
	localparam int RCOUNT_W = 8;
	localparam int TICK_W = 16;
	localparam int KIND_W = 3;
	localparam int OPCODE_W = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 48;

	localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_BYTE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_TICK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_RESPONSE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DONE_OK = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FORMAT_ERROR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_DATA_MODE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OK_CHAR = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR_CHAR = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd3;

	localparam logic [7:0] OK_CHAR_RST = 8'd79;
	localparam logic [7:0] TERMINATOR_CHAR_RST = 8'd10;
	localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd20000;

	localparam logic [7:0] COMMA_CHAR = 8'h2C;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;
	localparam logic [LEN_W-1:0] LEN_MAX = 14'd16383;
	localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

	typedef struct packed {
		logic data_mode;
		logic [7:0] ok_char;
		logic [7:0] terminator_char;
		logic [TICK_W-1:0] timeout_ticks;
	} mrf_cfg_t;

	typedef struct packed {
		logic valid;
		logic [KIND_W-1:0] kind;
		logic [7:0] data_byte;
		logic [LEN_W-1:0] position;
		logic [RCOUNT_W-1:0] response_length;
		logic [LEN_W-1:0] payload_length;
	} mrf_result_t;

endpackage

@@ hw/rtl/mrf_cfg_regs.sv @@
// Configuration register file of the modem response framer.
module mrf_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output mrf_pkg::mrf_cfg_t cfg
);

	mrf_pkg::mrf_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_mode <= 1'b0;
			cfg_q.ok_char <= mrf_pkg::OK_CHAR_RST;
			cfg_q.terminator_char <= mrf_pkg::TERMINATOR_CHAR_RST;
			cfg_q.timeout_ticks <= mrf_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mrf_pkg::REG_DATA_MODE: cfg_q.data_mode <= cfg_wdata[0];
				mrf_pkg::REG_OK_CHAR: cfg_q.ok_char <= cfg_wdata[7:0];
				mrf_pkg::REG_TERMINATOR_CHAR: cfg_q.terminator_char <= cfg_wdata[7:0];
				mrf_pkg::REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/mrf_parser.sv @@
// Reply parse state and the combinational update that produces at most one result.
module mrf_parser #(
	parameter int MAX_LENGTH_DIGITS = mrf_pkg::MAX_LENGTH_DIGITS_DEF,
	parameter int RESPONSE_DEPTH = mrf_pkg::RESPONSE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic enable,
	input  logic [mrf_pkg::OPCODE_W-1:0] opcode,
	input  logic [7:0] rx_byte,
	input  mrf_pkg::mrf_cfg_t cfg,
	output mrf_pkg::mrf_result_t result
);

	localparam int DC_W = $clog2(MAX_LENGTH_DIGITS + 1);
	localparam logic [DC_W-1:0] DIGITS_MAX = DC_W'(MAX_LENGTH_DIGITS);
	localparam logic [mrf_pkg::RCOUNT_W-1:0] RESP_LIMIT = mrf_pkg::RCOUNT_W'(RESPONSE_DEPTH - 1);

	logic active_q, active_d;
	logic ok_seen_q, ok_seen_d;
	logic [1:0] comma_count_q, comma_count_d;
	logic comma_pair_seen_q, comma_pair_seen_d;
	logic [mrf_pkg::RCOUNT_W-1:0] second_comma_index_q, second_comma_index_d;
	logic length_taken_q, length_taken_d;
	logic [mrf_pkg::LEN_W-1:0] length_acc_q, length_acc_d;
	logic [DC_W-1:0] digit_count_q, digit_count_d;
	logic digits_stopped_q, digits_stopped_d;
	logic [mrf_pkg::LEN_W-1:0] expected_payload_q, expected_payload_d;
	logic [mrf_pkg::LEN_W-1:0] payload_count_q, payload_count_d;
	logic [mrf_pkg::RCOUNT_W-1:0] response_count_q, response_count_d;
	logic [mrf_pkg::TICK_W-1:0] idle_ticks_q, idle_ticks_d;

	logic parse_on;
	logic is_comma;
	logic is_digit;
	logic is_term;
	logic [mrf_pkg::LEN_W+3:0] acc_times_ten;
	logic [mrf_pkg::LEN_W+3:0] acc_sum;

	assign is_comma = (rx_byte == mrf_pkg::COMMA_CHAR);
	assign is_digit = (rx_byte >= mrf_pkg::DIGIT_ZERO) && (rx_byte <= mrf_pkg::DIGIT_NINE);
	assign is_term = (rx_byte == cfg.terminator_char);
	assign acc_times_ten = {1'b0, length_acc_q, 3'b000} + {3'b000, length_acc_q, 1'b0};
	assign acc_sum = acc_times_ten + {{(mrf_pkg::LEN_W){1'b0}}, rx_byte[3:0]};

	always_comb begin
		active_d = active_q;
		ok_seen_d = ok_seen_q;
		comma_count_d = comma_count_q;
		comma_pair_seen_d = comma_pair_seen_q;
		second_comma_index_d = second_comma_index_q;
		length_taken_d = length_taken_q;
		length_acc_d = length_acc_q;
		digit_count_d = digit_count_q;
		digits_stopped_d = digits_stopped_q;
		expected_payload_d = expected_payload_q;
		payload_count_d = payload_count_q;
		response_count_d = response_count_q;
		idle_ticks_d = idle_ticks_q;
		result = '0;
		parse_on = 1'b0;

		if (opcode == mrf_pkg::OP_START) begin
			active_d = 1'b1;
			ok_seen_d = 1'b0;
			comma_count_d = 2'd0;
			comma_pair_seen_d = 1'b0;
			second_comma_index_d = '0;
			length_taken_d = 1'b0;
			length_acc_d = '0;
			digit_count_d = '0;
			digits_stopped_d = 1'b0;
			expected_payload_d = '0;
			payload_count_d = '0;
			response_count_d = '0;
			idle_ticks_d = '0;
		end else if (active_q && opcode == mrf_pkg::OP_BYTE) begin
			idle_ticks_d = '0;
			if (cfg.data_mode && response_count_q == '0 && rx_byte == cfg.ok_char) begin
				ok_seen_d = 1'b1;
			end
			parse_on = cfg.data_mode && ok_seen_d;

			if (parse_on && is_comma && !comma_pair_seen_q) begin
				if (comma_count_q == 2'd1) begin
					second_comma_index_d = response_count_q;
					comma_pair_seen_d = 1'b1;
				end
				comma_count_d = comma_count_q + 2'd1;
			end

			if (parse_on && !is_comma && comma_count_q == 2'd1 && !digits_stopped_q) begin
				if (is_digit && digit_count_q < DIGITS_MAX) begin
					if (acc_sum > {4'b0000, mrf_pkg::LEN_MAX}) begin
						length_acc_d = mrf_pkg::LEN_MAX;
					end else begin
						length_acc_d = acc_sum[mrf_pkg::LEN_W-1:0];
					end
					digit_count_d = digit_count_q + DC_W'(1);
					if (digit_count_d >= DIGITS_MAX) begin
						digits_stopped_d = 1'b1;
					end
				end else begin
					digits_stopped_d = 1'b1;
				end
			end

			if (parse_on && comma_pair_seen_d && !length_taken_q) begin
				expected_payload_d = length_acc_d;
				length_taken_d = 1'b1;
			end

			if (parse_on && length_taken_d && response_count_q > second_comma_index_d) begin
				if (payload_count_q < expected_payload_d) begin
					result.valid = 1'b1;
					result.kind = mrf_pkg::KIND_PAYLOAD;
					result.data_byte = rx_byte;
					result.position = payload_count_q;
					payload_count_d = payload_count_q + 14'd1;
				end else begin
					active_d = 1'b0;
					result.valid = 1'b1;
					if (is_term) begin
						result.kind = mrf_pkg::KIND_DONE_OK;
						result.response_length = response_count_q;
						result.payload_length = expected_payload_d;
					end else begin
						result.kind = mrf_pkg::KIND_FORMAT_ERROR;
					end
				end
			end else if (is_term) begin
				active_d = 1'b0;
				result.valid = 1'b1;
				result.kind = mrf_pkg::KIND_DONE_OK;
				result.response_length = response_count_q;
				result.payload_length = expected_payload_d;
			end else if (response_count_q < RESP_LIMIT) begin
				result.valid = 1'b1;
				result.kind = mrf_pkg::KIND_RESPONSE;
				result.data_byte = rx_byte;
				result.position = {6'b000000, response_count_q};
				response_count_d = response_count_q + 8'd1;
			end
		end else if (active_q && opcode == mrf_pkg::OP_TICK) begin
			if (idle_ticks_q < mrf_pkg::TICK_MAX) begin
				idle_ticks_d = idle_ticks_q + 16'd1;
			end
			if (idle_ticks_d > cfg.timeout_ticks) begin
				active_d = 1'b0;
				result.valid = 1'b1;
				result.kind = mrf_pkg::KIND_TIMEOUT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ok_seen_q <= 1'b0;
			comma_count_q <= 2'd0;
			comma_pair_seen_q <= 1'b0;
			second_comma_index_q <= '0;
			length_taken_q <= 1'b0;
			length_acc_q <= '0;
			digit_count_q <= '0;
			digits_stopped_q <= 1'b0;
			expected_payload_q <= '0;
			payload_count_q <= '0;
			response_count_q <= '0;
			idle_ticks_q <= '0;
		end else if (enable) begin
			active_q <= active_d;
			ok_seen_q <= ok_seen_d;
			comma_count_q <= comma_count_d;
			comma_pair_seen_q <= comma_pair_seen_d;
			second_comma_index_q <= second_comma_index_d;
			length_taken_q <= length_taken_d;
			length_acc_q <= length_acc_d;
			digit_count_q <= digit_count_d;
			digits_stopped_q <= digits_stopped_d;
			expected_payload_q <= expected_payload_d;
			payload_count_q <= payload_count_d;
			response_count_q <= response_count_d;
			idle_ticks_q <= idle_ticks_d;
		end
	end

endmodule

@@ hw/rtl/modem_response_framer_top.sv @@
// Modem response framer: input register, reply parser and result register.
// An accepted transaction is held in the input register; its result is registered in the result register.
// Throughput: one input transaction per cycle while the result register is not stalled.
// A stalled result register holds the input stage; the input register takes a
// new transaction whenever the stage ahead of it advances or is empty.
// Reset clears all parse state and loads the register defaults; no result is valid.
module modem_response_framer_top #(
	parameter int MAX_LENGTH_DIGITS = mrf_pkg::MAX_LENGTH_DIGITS_DEF,
	parameter int RESPONSE_DEPTH = mrf_pkg::RESPONSE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [mrf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mrf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [mrf_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [7:0] rx_byte
	input  logic [mrf_pkg::OPCODE_W-1:0] s_axis_tuser,    // [1:0] opcode
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [7:0] data_byte, [21:8] position, [29:22] response_length,
	// [43:30] payload_length, [47:44] zero
	output logic [mrf_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic [mrf_pkg::KIND_W-1:0] m_axis_tuser       // [2:0] kind
);

	mrf_pkg::mrf_cfg_t cfg;
	mrf_pkg::mrf_result_t result;
	mrf_pkg::mrf_result_t result_q;

	logic valid_s1;
	logic [mrf_pkg::OPCODE_W-1:0] opcode_s1;
	logic [7:0] rx_byte_s1;
	logic out_valid_q;
	logic advance;

	assign advance = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	mrf_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	mrf_parser #(
		.MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS),
		.RESPONSE_DEPTH(RESPONSE_DEPTH)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.enable(valid_s1 && advance),
		.opcode(opcode_s1),
		.rx_byte(rx_byte_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			opcode_s1 <= s_axis_tuser;
			rx_byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && result.valid) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = result_q.kind;
	assign m_axis_tdata = {4'b0000, result_q.payload_length, result_q.response_length,
		result_q.position, result_q.data_byte};

endmodule

@@ tb/sv/modem_response_framer_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the modem response framer top level.
module modem_response_framer_top_tb;
	import mrf_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int DIGIT_LIMIT = MAX_LENGTH_DIGITS_DEF;
	localparam int STORE_LIMIT = (RESPONSE_DEPTH_DEF - 1 > 255) ? 255 : RESPONSE_DEPTH_DEF - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [OPCODE_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0] m_axis_tuser;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int cycle_count = 0;
	int work_items = 0;

	logic data_mode_q = 1'b0;
	logic [7:0] ok_char_q = OK_CHAR_RST;
	logic [7:0] term_char_q = TERMINATOR_CHAR_RST;
	logic [TICK_W-1:0] timeout_q = TIMEOUT_TICKS_RST;

	logic reply_open, ok_seen, pair_seen, length_latched, digits_done;
	logic [1:0] comma_cnt;
	logic [RCOUNT_W-1:0] second_comma_pos, resp_cnt;
	logic [LEN_W-1:0] length_acc, payload_len, payload_cnt;
	logic [2:0] digit_cnt;
	logic [TICK_W-1:0] idle_cnt;

	mrf_result_t expected_results[$];

	modem_response_framer_top u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void clear_parse();
		reply_open = 1'b0;
		ok_seen = 1'b0;
		pair_seen = 1'b0;
		length_latched = 1'b0;
		digits_done = 1'b0;
		comma_cnt = '0;
		second_comma_pos = '0;
		resp_cnt = '0;
		length_acc = '0;
		payload_len = '0;
		payload_cnt = '0;
		digit_cnt = '0;
		idle_cnt = '0;
	endfunction

	function automatic void push_result(logic [KIND_W-1:0] k, logic [7:0] b,
			logic [LEN_W-1:0] pos, logic [RCOUNT_W-1:0] rlen, logic [LEN_W-1:0] plen);
		mrf_result_t r;
		r = '0;
		r.kind = k;
		r.data_byte = b;
		r.position = pos;
		r.response_length = rlen;
		r.payload_length = plen;
		expected_results.push_back(r);
	endfunction

	function automatic void close_reply(logic [KIND_W-1:0] k);
		reply_open = 1'b0;
		if (k == KIND_DONE_OK) begin
			push_result(k, '0, '0, resp_cnt, payload_len);
		end else begin
			push_result(k, '0, '0, '0, '0);
		end
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		int v;
		idle_cnt = '0;
		if (data_mode_q && resp_cnt == 0 && b == ok_char_q) ok_seen = 1'b1;
		if (data_mode_q && ok_seen && b == COMMA_CHAR && !pair_seen) begin
			if (comma_cnt == 2'd1) begin
				second_comma_pos = resp_cnt;
				pair_seen = 1'b1;
			end
			comma_cnt = comma_cnt + 2'd1;
		end
		if (data_mode_q && ok_seen && b != COMMA_CHAR && comma_cnt == 2'd1 && !digits_done) begin
			if (b >= DIGIT_ZERO && b <= DIGIT_NINE && digit_cnt < DIGIT_LIMIT) begin
				v = int'(length_acc) * 10 + int'(b - DIGIT_ZERO);
				length_acc = (v > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(v);
				digit_cnt = digit_cnt + 3'd1;
				if (digit_cnt >= DIGIT_LIMIT) digits_done = 1'b1;
			end else begin
				digits_done = 1'b1;
			end
		end
		if (data_mode_q && ok_seen && pair_seen && !length_latched) begin
			payload_len = length_acc;
			length_latched = 1'b1;
		end
		if (data_mode_q && ok_seen && length_latched && resp_cnt > second_comma_pos) begin
			if (payload_cnt < payload_len) begin
				push_result(KIND_PAYLOAD, b, payload_cnt, '0, '0);
				payload_cnt++;
			end else begin
				close_reply((b == term_char_q) ? KIND_DONE_OK : KIND_FORMAT_ERROR);
			end
		end else if (b == term_char_q) begin
			close_reply(KIND_DONE_OK);
		end else if (resp_cnt < STORE_LIMIT) begin
			push_result(KIND_RESPONSE, b, LEN_W'(resp_cnt), '0, '0);
			resp_cnt++;
		end
	endfunction

	function automatic void predict_item(logic [OPCODE_W-1:0] op, logic [7:0] b);
		if (op == OP_START || (reply_open && op != OP_UNUSED)) work_items++;
		if (op == OP_START) begin
			clear_parse();
			reply_open = 1'b1;
		end else if (reply_open && op == OP_BYTE) begin
			predict_byte(b);
		end else if (reply_open && op == OP_TICK) begin
			if (idle_cnt < TICK_MAX) idle_cnt++;
			if (idle_cnt > timeout_q) close_reply(KIND_TIMEOUT);
		end
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == COMMA_CHAR || b == term_char_q) b = 8'($urandom);
		return b;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		mrf_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected transaction, kind", m_axis_tuser, -1);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch("kind", m_axis_tuser, want.kind);
				if (m_axis_tdata[7:0] !== want.data_byte)
					report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
				if (m_axis_tdata[21:8] !== want.position)
					report_mismatch("position", m_axis_tdata[21:8], want.position);
				if (m_axis_tdata[29:22] !== want.response_length)
					report_mismatch("response_length", m_axis_tdata[29:22], want.response_length);
				if (m_axis_tdata[43:30] !== want.payload_length)
					report_mismatch("payload_length", m_axis_tdata[43:30], want.payload_length);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[modem_response_framer_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(logic [OPCODE_W-1:0] op, logic [7:0] b);
		int gaps;
		gaps = 0;
		while ($urandom_range(99) < send_gap_pct) gaps++;
		if (gaps > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_item(op, b);
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(99) < 5) send_item(OP_TICK, 8'($urandom));
		send_item(OP_BYTE, b);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		case (idx)
			REG_DATA_MODE: data_mode_q = value[0];
			REG_OK_CHAR: ok_char_q = value[7:0];
			REG_TERMINATOR_CHAR: term_char_q = value[7:0];
			REG_TIMEOUT_TICKS: timeout_q = value;
			default: ;
		endcase
	endtask

	task automatic configure(logic dm, logic [7:0] ok, logic [7:0] term,
			logic [TICK_W-1:0] limit);
		wait_idle();
		write_reg(REG_DATA_MODE, CFG_DATA_W'(dm));
		write_reg(REG_OK_CHAR, CFG_DATA_W'(ok));
		write_reg(REG_TERMINATOR_CHAR, CFG_DATA_W'(term));
		write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(limit));
		cfg_we <= 1'b0;
	endtask

	task automatic test_plain_reply();
		// Nothing is reported until a start opens a reply.
		send_item(OP_BYTE, 8'h00);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_UNUSED, 8'h5A);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_UNUSED, 8'hA5);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, TERMINATOR_CHAR_RST);
	endtask

	task automatic test_data_reply();
		configure(1'b1, OK_CHAR_RST, TERMINATOR_CHAR_RST, TIMEOUT_TICKS_RST);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, "x");
		// A second start drops the open reply; the length stops at the first non-digit.
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, OK_CHAR_RST);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, "1");
		send_item(OP_BYTE, "x");
		send_item(OP_BYTE, "2");
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, 8'hAA);
		send_item(OP_BYTE, 8'h55);
		// Four digits end the length field, so the fifth one is ignored.
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, OK_CHAR_RST);
		send_item(OP_BYTE, COMMA_CHAR);
		repeat (4) send_item(OP_BYTE, "0");
		send_item(OP_BYTE, "5");
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, TERMINATOR_CHAR_RST);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, OK_CHAR_RST);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, TERMINATOR_CHAR_RST);
	endtask

	task automatic test_register_extremes();
		configure(1'b1, 8'h00, 8'hFF, '0);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, "2");
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_START, 8'h00);
		send_item(OP_TICK, 8'h00);
		// The response store fills up and the terminator still closes the reply.
		configure(1'b0, 8'hFF, 8'h00, TICK_MAX);
		send_item(OP_START, 8'h00);
		repeat (260) send_item(OP_BYTE, 8'($urandom_range(1, 255)));
		send_item(OP_BYTE, 8'h00);
		configure(1'b1, 8'hFF, 8'h00, TICK_MAX);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, 8'h00);
	endtask

	task automatic test_timeouts();
		configure(1'b1, OK_CHAR_RST, TERMINATOR_CHAR_RST, 16'd3);
		send_item(OP_START, 8'h00);
		repeat (3) send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, "A");
		repeat (4) send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		configure(1'b0, OK_CHAR_RST, TERMINATOR_CHAR_RST, 16'd20);
		send_item(OP_START, 8'h00);
		repeat (21) send_item(OP_TICK, 8'($urandom));
		// The largest limit never expires.
		configure(1'b0, OK_CHAR_RST, TERMINATOR_CHAR_RST, TICK_MAX);
		send_item(OP_START, 8'h00);
		repeat (20) send_item(OP_TICK, 8'($urandom));
		send_item(OP_BYTE, "A");
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, TERMINATOR_CHAR_RST);
	endtask

	task automatic test_four_digit_payload();
		configure(1'b1, OK_CHAR_RST, TERMINATOR_CHAR_RST, TICK_MAX);
		send_item(OP_START, 8'h00);
		send_item(OP_BYTE, OK_CHAR_RST);
		send_item(OP_BYTE, COMMA_CHAR);
		send_item(OP_BYTE, "0");
		send_item(OP_BYTE, "0");
		send_item(OP_BYTE, "3");
		send_item(OP_BYTE, "0");
		send_item(OP_BYTE, COMMA_CHAR);
		repeat (30) send_item(OP_BYTE, 8'($urandom));
		send_item(OP_BYTE, TERMINATOR_CHAR_RST);
	endtask

	task automatic pick_settings();
		logic dm;
		logic [7:0] ok, term;
		logic [TICK_W-1:0] limit;
		int r;
		dm = ($urandom_range(3) != 0);
		ok = $urandom_range(1) ? OK_CHAR_RST : 8'($urandom);
		while (ok == COMMA_CHAR) ok = 8'($urandom);
		term = $urandom_range(1) ? TERMINATOR_CHAR_RST : 8'($urandom);
		while (term == COMMA_CHAR || term == ok || (term >= DIGIT_ZERO && term <= DIGIT_NINE))
			term = 8'($urandom);
		r = $urandom_range(99);
		if (r < 50) limit = 16'($urandom_range(40));
		else if (r < 80) limit = 16'($urandom_range(41, 500));
		else limit = TICK_MAX;
		configure(dm, ok, term, limit);
	endtask

	task automatic send_data_reply();
		int plen, r, cut;
		string digits;
		r = $urandom_range(99);
		if (r < 80) plen = $urandom_range(15);
		else if (r < 95) plen = $urandom_range(16, 60);
		else plen = $urandom_range(61, 200);
		digits = $sformatf("%0d", plen);
		while (digits.len() < DIGIT_LIMIT && $urandom_range(3) == 0) digits = {"0", digits};
		if (plen == 0 && $urandom_range(3) == 0) digits = "";
		send_item(OP_START, 8'($urandom));
		send_byte(ok_char_q);
		repeat ($urandom_range(3)) send_byte(plain_byte());
		send_byte(COMMA_CHAR);
		for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
		if ($urandom_range(9) == 0) send_byte(plain_byte());
		send_byte(COMMA_CHAR);
		cut = ($urandom_range(9) == 0) ? $urandom_range(plen) : plen;
		repeat (cut) send_byte(8'($urandom));
		if (cut == plen) send_byte(($urandom_range(4) != 0) ? term_char_q : 8'($urandom));
	endtask

	task automatic send_plain_reply();
		send_item(OP_START, 8'($urandom));
		repeat ($urandom_range(20)) send_byte(plain_byte());
		send_item(OP_BYTE, term_char_q);
	endtask

	task automatic send_noise();
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(1, 45)) send_item(OP_TICK, 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 6)) send_item(2'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_random_replies(int goal);
		int stop_at, r;
		for (int half = 0; half < 2; half++) begin
			pick_settings();
			stop_at = work_items + goal / 2;
			while (work_items < stop_at) begin
				r = $urandom_range(99);
				if (r < 60) send_data_reply();
				else if (r < 75) send_plain_reply();
				else send_noise();
			end
		end
	endtask

	initial begin
		clear_parse();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_gap_pct = 15;
		recv_stall_pct = 75;
		test_plain_reply();
		test_data_reply();
		test_register_extremes();
		test_random_replies(70);
		send_gap_pct = 75;
		recv_stall_pct = 15;
		test_random_replies(70);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random_replies(70);
		test_timeouts();
		test_four_digit_payload();
		wait_idle();
		if (error_count == 0) begin
			$display("[modem_response_framer_top] OK");
		end else begin
			$display("[modem_response_framer_top] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/mrf_pkg.sv
hw/rtl/mrf_cfg_regs.sv
hw/rtl/mrf_parser.sv
hw/rtl/modem_response_framer_top.sv
tb/sv/modem_response_framer_top_tb.sv
